// ===== sv/multichannel_spike_peak_detector_macros.svh =====
// Assertion macros shared by the checker of the spike peak detector.
// Depends on nothing; included by the checker file.
`ifndef MULTICHANNEL_SPIKE_PEAK_DETECTOR_MACROS_SVH
`define MULTICHANNEL_SPIKE_PEAK_DETECTOR_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define MSPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that is also checked across reset.
`define MSPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mspd_pkg.sv =====
// Types and constants of the multichannel spike peak detector.
// Depends on nothing; used by the interfaces, the history store and the top level.
package mspd_pkg;

  localparam int TIME_W   = 32;
  localparam int CHAN_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int CHAN_SPAN = 2 ** CHAN_W;

  typedef logic [TIME_W-1:0]          time_t;
  typedef logic [CHAN_W-1:0]          chan_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t MOST_NEGATIVE   = sample_t'(16'h8000);
  localparam sample_t THRESHOLD_RESET = sample_t'(16'sd128);

  // Configuration port: one register, word addressed on a 32-bit bus.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_SPIKE_THRESHOLD = 1'b0;

  // Output queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  typedef logic [FIFO_AW:0] fifo_cnt_t;

  // Per-channel history: the two most recent samples.
  typedef struct packed {
    sample_t older;
    sample_t previous;
  } hist_t;

  localparam hist_t HIST_CLEAR = '{older: MOST_NEGATIVE, previous: MOST_NEGATIVE};

  // Access request from the datapath to the history store.
  typedef struct packed {
    logic  rd;
    chan_t rd_addr;
    logic  wr;
    chan_t wr_addr;
    hist_t wr_data;
  } hist_req_t;

  typedef struct packed {
    time_t spike_time;
    chan_t spike_channel;
  } spike_t;

endpackage

// ===== sv/mspd_if.sv =====
// Valid/ready channel interfaces for samples in and spike reports out.
// Depends on mspd_pkg.
interface mspd_sample_if;
  import mspd_pkg::*;

  logic    valid;
  logic    ready;
  time_t   time_stamp;
  chan_t   channel;
  sample_t sample;

  modport source (output valid, time_stamp, channel, sample, input ready);
  modport sink (input valid, time_stamp, channel, sample, output ready);
endinterface

interface mspd_spike_if;
  import mspd_pkg::*;

  logic  valid;
  logic  ready;
  time_t spike_time;
  chan_t spike_channel;

  modport source (output valid, spike_time, spike_channel, input ready);
  modport sink (input valid, spike_time, spike_channel, output ready);
endinterface

// ===== sv/mspd_hist.sv =====
// Per-channel history memory: one read and one write port, read data registered.
// Clears itself after reset and forwards a write to a read of the same entry.
// Depends on mspd_pkg.
module mspd_hist #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  mspd_pkg::hist_req_t req,
  output mspd_pkg::hist_t   rd_data,
  output logic              busy
);
  import mspd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hist_t          mem [DEPTH];
  hist_t          mem_q;
  hist_t          fwd_data;
  logic           fwd_hit;
  logic [AW-1:0]  clr_cnt;

  // Clearing sweep, one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      if (clr_cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= HIST_CLEAR;
    end else if (req.wr) begin
      mem[AW'(req.wr_addr)] <= req.wr_data;
    end
    if (req.rd) begin
      mem_q <= mem[AW'(req.rd_addr)];
    end
  end

  // A write landing on the entry read at the same edge overrides the stale read.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= req.rd && req.wr && (req.rd_addr == req.wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      fwd_data <= req.wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

// ===== sv/multichannel_spike_peak_detector.sv =====
// Top level of the multichannel spike peak detector.
// Depends on mspd_pkg, mspd_if.sv (channel interfaces) and mspd_hist.
//
// The detector takes an interleaved stream of voltage samples, each tagged with a time stamp and
// a channel index, and reports a spike whenever a channel's previous sample lies strictly above
// the programmable threshold and strictly above both the sample before it and the sample just
// received. The report carries the time stamp of the sample that follows the peak and the
// channel. One sample transaction is accepted every clock cycle unless the clearing sweep or a
// full report queue holds the input off; a spike transaction passes the input stage into the
// report queue. The figure of one sample per cycle is set by the history memory's separate read
// and write ports: an entry is read in the cycle a sample is accepted and written back in the
// next, while the following sample is being read; a sample that follows one on the same channel
// picks up the pending write through a forwarding register. Samples whose channel index is not
// below NUM_CHANNELS are accepted and dropped without touching any history. After reset the
// history memory is swept to the most negative voltage, one entry per channel up to 256, during
// which no sample is accepted; the threshold register can be written throughout. Spike reports
// wait in a four-entry queue, so the sample side keeps moving while a report waits to be taken,
// until the queue is nearly full. The threshold (signed Q8.8, reset value 0.5) sits at byte
// address 0 of the configuration port and should only be changed while no samples are in flight.
module multichannel_spike_peak_detector #(
  parameter int NUM_CHANNELS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  mspd_sample_if.sink                         samples,
  mspd_spike_if.source                        spikes,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mspd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mspd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mspd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mspd_pkg::*;

  // Channel indices are eight bits wide, so no more than 256 entries can ever be addressed.
  localparam int MEM_DEPTH = (NUM_CHANNELS > CHAN_SPAN) ? CHAN_SPAN : NUM_CHANNELS;

  // ---------------------------------------------------------------- configuration register
  sample_t spike_threshold;
  logic    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && (reg_sel == REG_SPIKE_THRESHOLD)) begin
      spike_threshold <= sample_t'(pwdata[SAMPLE_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_SPIKE_THRESHOLD) begin
      prdata = APB_DATA_W'(spike_threshold);
    end
  end

  // ---------------------------------------------------------------- input stage
  logic      accept;
  logic      in_range;
  logic      hist_busy;
  logic      s1_valid;
  time_t     s1_time;
  chan_t     s1_chan;
  sample_t   s1_sample;
  fifo_cnt_t fifo_cnt;

  // Room is kept for both the item now being resolved and the one about to be accepted, so the
  // decision needs no look at the output side's ready.
  assign samples.ready = !hist_busy &&
                         ((fifo_cnt + fifo_cnt_t'(s1_valid)) <= fifo_cnt_t'(FIFO_DEPTH - 1));
  assign accept   = samples.valid && samples.ready;
  assign in_range = (32'(samples.channel) < 32'(NUM_CHANNELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_time   <= samples.time_stamp;
      s1_chan   <= samples.channel;
      s1_sample <= samples.sample;
    end
  end

  // ---------------------------------------------------------------- history memory
  hist_req_t hist_req;
  hist_t     hist;

  assign hist_req.rd              = accept && in_range;
  assign hist_req.rd_addr         = samples.channel;
  assign hist_req.wr              = s1_valid;
  assign hist_req.wr_addr         = s1_chan;
  assign hist_req.wr_data.older   = hist.previous;
  assign hist_req.wr_data.previous = s1_sample;

  mspd_hist #(
    .DEPTH (MEM_DEPTH)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .req     (hist_req),
    .rd_data (hist),
    .busy    (hist_busy)
  );

  // ---------------------------------------------------------------- peak test
  // The middle sample is a peak when it beats the threshold and both of its neighbours.
  logic peak;

  assign peak = s1_valid &&
                (hist.previous > spike_threshold) &&
                (hist.previous > s1_sample) &&
                (hist.previous > hist.older);

  // ---------------------------------------------------------------- report queue
  spike_t              fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic                push;
  logic                pop;
  spike_t              head;

  assign push = peak;
  assign pop  = spikes.valid && spikes.ready;
  assign head = fifo[rd_ptr];

  assign spikes.valid         = (fifo_cnt != '0);
  assign spikes.spike_time    = head.spike_time;
  assign spikes.spike_channel = head.spike_channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fifo_cnt <= fifo_cnt + 1'b1;
      end else if (pop && !push) begin
        fifo_cnt <= fifo_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{spike_time: s1_time, spike_channel: s1_chan};
    end
  end

endmodule

// ===== sv/mspd_checker.sv =====
// Port-level checker for the multichannel spike peak detector, with its bind statement.
// Depends on multichannel_spike_peak_detector_macros.svh and mspd_pkg.
`include "multichannel_spike_peak_detector_macros.svh"

module mspd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input mspd_pkg::time_t       spike_time,
  input mspd_pkg::chan_t       spike_channel
);
  import mspd_pkg::*;

  // Straight after reset the queue is empty and the clearing sweep holds off samples.
  `MSPD_ASSERT_ALWAYS(a_quiet_after_reset, clk, rst |=> (!out_valid && !in_ready), "detector not quiet after reset")

  // A report only starts after a sample transaction has passed the input stage into the queue.
  `MSPD_ASSERT(a_report_has_cause, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "spike report without a sample two cycles earlier")

  // A report that is not taken stays and keeps its contents.
  `MSPD_ASSERT(a_report_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(spike_time) && $stable(spike_channel)), "spike report changed while stalled")

  // Both handshake outputs are always driven to a known level once reset is released.
  `MSPD_ASSERT(a_ready_known, clk, rst, !$isunknown(in_ready) && !$isunknown(out_valid), "handshake signal unknown")

endmodule

bind multichannel_spike_peak_detector mspd_checker u_mspd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (spikes.valid),
  .out_ready     (spikes.ready),
  .spike_time    (spikes.spike_time),
  .spike_channel (spikes.spike_channel)
);
